// ===== sv/ndef_t2_pkg.sv =====
package ndef_t2_pkg;

  // Default build constants
  localparam int NEST_DEPTH_DEF    = 4;
  localparam int POSITION_BITS_DEF = 16;
  localparam logic [15:0] MEM_LEN_RESET = 16'd888;

  // TLV codes
  localparam logic [7:0] TLV_NULL = 8'h00;
  localparam logic [7:0] TLV_NDEF = 8'h03;
  localparam logic [7:0] TLV_TERM = 8'hFE;
  localparam logic [7:0] TLV_LEN_ESC = 8'hFF;

  // NDEF record header flags and fields
  localparam logic [7:0] HDR_ME       = 8'h40;
  localparam logic [7:0] HDR_SR       = 8'h10;
  localparam logic [7:0] HDR_IL       = 8'h08;
  localparam logic [7:0] HDR_TNF_MASK = 8'h07;
  localparam logic [7:0] TNF_WELL_KNOWN = 8'h01;
  localparam logic [7:0] LANG_LEN_MASK  = 8'h3F;

  // Record type characters
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_P = 8'h70;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
  } out_item_t;

endpackage

// ===== sv/ndef_t2_in_stage.sv =====
module ndef_t2_in_stage
  import ndef_t2_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // Stall only when the held transaction cannot move on
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on acceptance
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== sv/ndef_t2_parser.sv =====
module ndef_t2_parser
  import ndef_t2_pkg::*;
#(
  parameter int NEST_DEPTH    = NEST_DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  input  logic [15:0] mem_len,
  output logic        res_valid,
  output out_item_t   res
);

  localparam int PB    = POSITION_BITS;
  localparam int LVL_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam logic [15:0]  POS_LIM   = 16'((1 << PB) - 1);
  localparam logic [LVL_W:0] DEPTH_L = (LVL_W + 1)'(NEST_DEPTH);
  localparam logic [16:0]  REC_MIN   = 17'd3;

  // Parse phases
  localparam logic [4:0] PH_TLV_TYPE   = 5'd0;
  localparam logic [4:0] PH_TLV_LEN    = 5'd1;
  localparam logic [4:0] PH_TLV_LEN_HI = 5'd2;
  localparam logic [4:0] PH_TLV_LEN_LO = 5'd3;
  localparam logic [4:0] PH_TLV_CHECK  = 5'd4;
  localparam logic [4:0] PH_TLV_SKIP   = 5'd5;
  localparam logic [4:0] PH_REC_START  = 5'd6;
  localparam logic [4:0] PH_HDR        = 5'd7;
  localparam logic [4:0] PH_TYPELEN    = 5'd8;
  localparam logic [4:0] PH_PLEN_S     = 5'd9;
  localparam logic [4:0] PH_PLEN_L     = 5'd10;
  localparam logic [4:0] PH_IDLEN      = 5'd11;
  localparam logic [4:0] PH_BODY_CHECK = 5'd12;
  localparam logic [4:0] PH_TYPE       = 5'd13;
  localparam logic [4:0] PH_ID         = 5'd14;
  localparam logic [4:0] PH_CLASSIFY   = 5'd15;
  localparam logic [4:0] PH_STATUS     = 5'd16;
  localparam logic [4:0] PH_LANG       = 5'd17;
  localparam logic [4:0] PH_TEXT       = 5'd18;
  localparam logic [4:0] PH_SKIP_PAY   = 5'd19;
  localparam logic [4:0] PH_REC_END    = 5'd20;
  localparam logic [4:0] PH_EXIT       = 5'd21;
  localparam logic [4:0] PH_EXIT_SKIP  = 5'd22;
  localparam logic [4:0] PH_IDLE       = 5'd23;

  // Parser state
  logic [PB-1:0]    pos_r,        pos_nxt;
  logic [4:0]       phase_r,      phase_nxt;
  logic [15:0]      tlv_len_r,    tlv_len_nxt;
  logic [7:0]       hdr_r,        hdr_nxt;
  logic [7:0]       typ_len_r,    typ_len_nxt;
  logic [7:0]       id_len_r,     id_len_nxt;
  logic [31:0]      pay_len_r,    pay_len_nxt;
  logic [15:0]      type_bytes_r, type_bytes_nxt;
  logic [31:0]      cdown_r,      cdown_nxt;
  logic [LVL_W-1:0] level_r,      level_nxt;
  logic             finished_r,   finished_nxt;
  logic [PB:0]      stack_r [NEST_DEPTH];

  // Working signals
  logic [PB-1:0]    eff_len;
  logic [PB-1:0]    pos_inc;
  logic [PB-1:0]    end_cur;
  logic [16:0]      tlv_sum;
  logic [33:0]      body_sum;
  logic [7:0]       type_idx;
  logic [7:0]       lang_cnt;
  logic             wk;
  logic             wr0;
  logic             push;
  logic [LVL_W-1:0] push_lvl;
  logic [PB:0]      ends_w [NEST_DEPTH];
  logic [NEST_DEPTH-1:0] stack_we;
  logic [NEST_DEPTH-1:0] near_end;
  logic [NEST_DEPTH-1:0] past_end;
  logic [NEST_DEPTH-1:0] me_flag;
  logic             t_valid;
  logic [7:0]       t_byte;
  logic             done;
  logic             ok;

  // Memory length clipped to the position range
  assign eff_len = (mem_len > POS_LIM) ? POS_LIM[PB-1:0] : mem_len[PB-1:0];

  always_comb begin
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    tlv_len_nxt    = tlv_len_r;
    hdr_nxt        = hdr_r;
    typ_len_nxt    = typ_len_r;
    id_len_nxt     = id_len_r;
    pay_len_nxt    = pay_len_r;
    type_bytes_nxt = type_bytes_r;
    cdown_nxt      = cdown_r;
    level_nxt      = level_r;
    finished_nxt   = finished_r;
    t_valid  = 1'b0;
    t_byte   = 8'h00;
    done     = 1'b0;
    ok       = 1'b0;
    wr0      = 1'b0;
    push     = 1'b0;
    push_lvl = '0;
    pos_inc  = '0;
    tlv_sum  = '0;
    body_sum = '0;
    type_idx = '0;
    lang_cnt = '0;
    wk       = 1'b0;
    end_cur  = '0;
    near_end = '0;
    past_end = '0;
    me_flag  = '0;
    stack_we = '0;
    for (int j = 0; j < NEST_DEPTH; j++) begin
      ends_w[j] = stack_r[j];
    end

    // Restart on the first byte of an image
    if (item.image_start) begin
      pos_nxt        = '0;
      phase_nxt      = PH_TLV_TYPE;
      tlv_len_nxt    = '0;
      hdr_nxt        = '0;
      typ_len_nxt    = '0;
      id_len_nxt     = '0;
      pay_len_nxt    = '0;
      type_bytes_nxt = '0;
      cdown_nxt      = '0;
      level_nxt      = '0;
      finished_nxt   = 1'b0;
    end

    end_cur = stack_r[level_nxt][PB-1:0];

    if (!finished_nxt) begin
      if (pos_nxt >= eff_len) begin
        done = 1'b1; finished_nxt = 1'b1; phase_nxt = PH_IDLE;
      end else begin
        // Consume the byte
        unique case (phase_nxt) inside
          PH_TLV_TYPE: begin
            if (item.data_byte == TLV_TERM) begin
              done = 1'b1; finished_nxt = 1'b1; phase_nxt = PH_IDLE;
            end else if (item.data_byte != TLV_NULL) begin
              hdr_nxt   = item.data_byte;
              phase_nxt = PH_TLV_LEN;
            end
          end
          PH_TLV_LEN: begin
            if (item.data_byte == TLV_LEN_ESC) begin
              phase_nxt = PH_TLV_LEN_HI;
            end else begin
              tlv_len_nxt = {8'h00, item.data_byte};
              phase_nxt   = PH_TLV_CHECK;
            end
          end
          PH_TLV_LEN_HI: begin
            tlv_len_nxt = {item.data_byte, 8'h00};
            phase_nxt   = PH_TLV_LEN_LO;
          end
          PH_TLV_LEN_LO: begin
            tlv_len_nxt = tlv_len_nxt | {8'h00, item.data_byte};
            phase_nxt   = PH_TLV_CHECK;
          end
          PH_HDR: begin
            hdr_nxt   = item.data_byte;
            phase_nxt = PH_TYPELEN;
          end
          PH_TYPELEN: begin
            typ_len_nxt = item.data_byte;
            if ((hdr_nxt & HDR_SR) != 8'h00) begin
              phase_nxt = PH_PLEN_S;
            end else begin
              pay_len_nxt = '0;
              cdown_nxt   = 32'd4;
              phase_nxt   = PH_PLEN_L;
            end
          end
          PH_PLEN_S: begin
            pay_len_nxt = {24'h0, item.data_byte};
            if ((hdr_nxt & HDR_IL) != 8'h00) begin
              phase_nxt = PH_IDLEN;
            end else begin
              id_len_nxt = '0;
              phase_nxt  = PH_BODY_CHECK;
            end
          end
          PH_PLEN_L: begin
            pay_len_nxt = {pay_len_nxt[23:0], item.data_byte};
            if (cdown_nxt != 32'd0) begin
              cdown_nxt = cdown_nxt - 32'd1;
            end
            if (cdown_nxt == 32'd0) begin
              if ((hdr_nxt & HDR_IL) != 8'h00) begin
                phase_nxt = PH_IDLEN;
              end else begin
                id_len_nxt = '0;
                phase_nxt  = PH_BODY_CHECK;
              end
            end
          end
          PH_IDLEN: begin
            id_len_nxt = item.data_byte;
            phase_nxt  = PH_BODY_CHECK;
          end
          PH_TYPE: begin
            type_idx = typ_len_nxt - cdown_nxt[7:0];
            if (type_idx == 8'd0) begin
              type_bytes_nxt = {item.data_byte, 8'h00};
            end else if (type_idx == 8'd1) begin
              type_bytes_nxt = type_bytes_nxt | {8'h00, item.data_byte};
            end
            cdown_nxt = cdown_nxt - 32'd1;
          end
          PH_STATUS: begin
            lang_cnt = item.data_byte & LANG_LEN_MASK;
            if ({24'h0, lang_cnt} + 32'd1 > pay_len_nxt) begin
              cdown_nxt = pay_len_nxt - 32'd1;
              phase_nxt = PH_SKIP_PAY;
            end else begin
              cdown_nxt   = {24'h0, lang_cnt};
              pay_len_nxt = pay_len_nxt - 32'd1 - {24'h0, lang_cnt};
              phase_nxt   = PH_LANG;
            end
          end
          PH_TEXT: begin
            t_valid     = 1'b1;
            t_byte      = item.data_byte;
            pay_len_nxt = pay_len_nxt - 32'd1;
          end
          PH_TLV_SKIP, PH_ID, PH_LANG, PH_SKIP_PAY: begin
            if (cdown_nxt != 32'd0) begin
              cdown_nxt = cdown_nxt - 32'd1;
            end
          end
          default: ;
        endcase

        if (!finished_nxt) begin
          pos_inc = pos_nxt + 1'b1;
          pos_nxt = pos_inc;

          // TLV length check and NDEF open
          if (phase_nxt == PH_TLV_CHECK) begin
            tlv_sum = 17'(pos_inc) + 17'(tlv_len_nxt);
            if (tlv_sum > 17'(eff_len)) begin
              done = 1'b1; finished_nxt = 1'b1; phase_nxt = PH_IDLE;
            end else if (hdr_nxt == TLV_NDEF) begin
              if (tlv_len_nxt == 16'd0) begin
                done = 1'b1; finished_nxt = 1'b1; phase_nxt = PH_IDLE;
              end else begin
                wr0       = 1'b1;
                ends_w[0] = {1'b0, tlv_sum[PB-1:0]};
                level_nxt = '0;
                phase_nxt = PH_REC_START;
              end
            end else begin
              cdown_nxt = {16'h0, tlv_len_nxt};
              phase_nxt = PH_TLV_SKIP;
            end
          end

          // Leave a skipped TLV
          if (phase_nxt == PH_TLV_SKIP && cdown_nxt == 32'd0) begin
            phase_nxt = PH_TLV_TYPE;
          end

          // Record header runs past its container
          if ((phase_nxt == PH_PLEN_S || phase_nxt == PH_PLEN_L ||
               phase_nxt == PH_IDLEN) && pos_inc >= end_cur) begin
            phase_nxt = PH_EXIT;
          end

          // Record body must fit its container
          if (phase_nxt == PH_BODY_CHECK) begin
            body_sum = 34'(pos_inc) + 34'(typ_len_nxt) + 34'(id_len_nxt) +
                       34'(pay_len_nxt);
            if (body_sum > 34'(end_cur)) begin
              phase_nxt = PH_EXIT;
            end else begin
              cdown_nxt      = {24'h0, typ_len_nxt};
              type_bytes_nxt = '0;
              phase_nxt      = PH_TYPE;
            end
          end

          if (phase_nxt == PH_TYPE && cdown_nxt == 32'd0) begin
            cdown_nxt = {24'h0, id_len_nxt};
            phase_nxt = PH_ID;
          end

          if (phase_nxt == PH_ID && cdown_nxt == 32'd0) begin
            phase_nxt = PH_CLASSIFY;
          end

          // Pick text record, smart poster descent or skip
          if (phase_nxt == PH_CLASSIFY) begin
            wk = (hdr_nxt & HDR_TNF_MASK) == TNF_WELL_KNOWN;
            if (wk && typ_len_nxt == 8'd1 && type_bytes_nxt[15:8] == CHAR_T &&
                pay_len_nxt != 32'd0) begin
              phase_nxt = PH_STATUS;
            end else if (wk && typ_len_nxt == 8'd2 &&
                         type_bytes_nxt == {CHAR_S, CHAR_P} &&
                         pay_len_nxt != 32'd0 &&
                         ({1'b0, level_nxt} + 1'b1) < DEPTH_L) begin
              push      = 1'b1;
              push_lvl  = level_nxt + 1'b1;
              level_nxt = push_lvl;
              ends_w[push_lvl] = {((hdr_nxt & HDR_ME) != 8'h00),
                                  pos_inc + pay_len_nxt[PB-1:0]};
              phase_nxt = PH_REC_START;
            end else begin
              cdown_nxt = pay_len_nxt;
              phase_nxt = PH_SKIP_PAY;
            end
          end

          if (phase_nxt == PH_LANG && cdown_nxt == 32'd0) begin
            phase_nxt = PH_TEXT;
          end

          // Text complete
          if (phase_nxt == PH_TEXT && pay_len_nxt == 32'd0) begin
            done = 1'b1; ok = 1'b1; finished_nxt = 1'b1; phase_nxt = PH_IDLE;
          end

          if (phase_nxt == PH_SKIP_PAY && cdown_nxt == 32'd0) begin
            phase_nxt = PH_REC_END;
          end

          if (phase_nxt == PH_REC_END) begin
            phase_nxt = ((hdr_nxt & HDR_ME) != 8'h00) ? PH_EXIT : PH_REC_START;
          end

          // Container end tests for every level at once
          for (int j = 0; j < NEST_DEPTH; j++) begin
            near_end[j] = (17'(pos_inc) + REC_MIN) > 17'(ends_w[j][PB-1:0]);
            past_end[j] = pos_inc >= ends_w[j][PB-1:0];
            me_flag[j]  = ends_w[j][PB];
          end

          // Walk down through ended containers
          for (int i = 0; i <= NEST_DEPTH; i++) begin
            if (phase_nxt == PH_REC_START) begin
              phase_nxt = near_end[level_nxt] ? PH_EXIT : PH_HDR;
            end
            if (phase_nxt == PH_EXIT) begin
              if (level_nxt == '0) begin
                done = 1'b1; finished_nxt = 1'b1; phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_EXIT_SKIP;
              end
            end
            if (phase_nxt == PH_EXIT_SKIP && past_end[level_nxt]) begin
              phase_nxt = me_flag[level_nxt] ? PH_EXIT : PH_REC_START;
              level_nxt = level_nxt - 1'b1;
            end
          end

          // Memory end or position wrap
          if (!finished_nxt && (pos_inc >= eff_len || pos_inc == '0)) begin
            done = 1'b1; finished_nxt = 1'b1; phase_nxt = PH_IDLE;
          end
        end
      end
    end

    for (int j = 0; j < NEST_DEPTH; j++) begin
      stack_we[j] = (wr0 && j == 0) || (push && int'(push_lvl) == j);
    end
  end

  // Advance the parser state once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= PH_TLV_TYPE;
      tlv_len_r    <= '0;
      hdr_r        <= '0;
      typ_len_r    <= '0;
      id_len_r     <= '0;
      pay_len_r    <= '0;
      type_bytes_r <= '0;
      cdown_r      <= '0;
      level_r      <= '0;
      finished_r   <= 1'b1;
    end else if (step) begin
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      tlv_len_r    <= tlv_len_nxt;
      hdr_r        <= hdr_nxt;
      typ_len_r    <= typ_len_nxt;
      id_len_r     <= id_len_nxt;
      pay_len_r    <= pay_len_nxt;
      type_bytes_r <= type_bytes_nxt;
      cdown_r      <= cdown_nxt;
      level_r      <= level_nxt;
      finished_r   <= finished_nxt;
    end
  end

  // Container end stack: end position plus ME flag of the opening record
  always_ff @(posedge clk) begin
    for (int j = 0; j < NEST_DEPTH; j++) begin
      if (step && stack_we[j]) begin
        stack_r[j] <= ends_w[j];
      end
    end
  end

  assign res_valid      = t_valid || done;
  assign res.text_byte  = t_byte;
  assign res.byte_valid = t_valid;
  assign res.done_res   = done;
  assign res.found      = done && ok;

endmodule

// ===== sv/ndef_t2_out_stage.sv =====
module ndef_t2_out_stage
  import ndef_t2_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      res_valid,
  input  out_item_t res,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // Free when empty or when the held transaction leaves this cycle
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/ndef_type2_text_extractor_core.sv =====
// Path: a byte accepted into the input register passes through the parser
//   next-state logic into the result register when the result slot is free.
// Throughput: one tag memory byte per cycle while out_stall is low, set by the
//   single-pass parser next-state logic between the two registers.
// Reset (synchronous, rst_n low): parser waits for an image start, both
//   registers empty, memory length returns to 888.
module ndef_type2_text_extractor_core
  import ndef_t2_pkg::*;
#(
  parameter int NEST_DEPTH    = NEST_DEPTH_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] mem_len_q_r;
  logic        item_valid;
  in_item_t    item;
  logic        out_ready;
  logic        step;
  logic        res_valid;
  out_item_t   res;

  // Memory length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_len_q_r <= MEM_LEN_RESET;
    end else if (cfg_wr_en) begin
      mem_len_q_r <= cfg_wr_data;
    end
  end

  // Move a held byte through the parser when the result slot is free
  assign step = item_valid && out_ready;

  ndef_t2_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  ndef_t2_parser #(
    .NEST_DEPTH    (NEST_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .mem_len   (mem_len_q_r),
    .res_valid (res_valid),
    .res       (res)
  );

  ndef_t2_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
